/* hw/rtl/aes128_block_encrypt_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the AES-128 encryption block
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/aes_pkg.sv */
// ----------------------------------------------------------------------------
// AES package
// Round count, state type and byte-level round functions.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned NumStages = NumRounds + 1;
  localparam logic [7:0] Poly = 8'h1B;

  typedef logic [127:0] block_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(input logic [7:0] a);
    gf_double = {a[6:0], 1'b0} ^ (a[7] ? Poly : 8'h00);
  endfunction

  // Byte k of the block, k = 0 at the top.
  function automatic logic [7:0] get_byte(input block_t b, input int unsigned k);
    get_byte = b[127 - 8*k -: 8];
  endfunction

endpackage

/* hw/rtl/aes_round_cell.sv */
// ----------------------------------------------------------------------------
// AES round cell
// One cipher round plus the matching key-schedule step, registered.
// ----------------------------------------------------------------------------
module aes_round_cell (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic            last_i,
  input  logic [7:0]      rcon_i,
  input  aes_pkg::block_t state_i,
  input  aes_pkg::block_t key_i,
  output aes_pkg::block_t state_o,
  output aes_pkg::block_t key_o
);

  aes_pkg::block_t state_d, state_q, key_d, key_q;
  logic [7:0] t [16];
  logic [7:0] k [16];
  logic [7:0] nk [16];
  logic [7:0] m [16];

  always_comb begin
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r + 4*c] = aes_pkg::SBOX[aes_pkg::get_byte(state_i, r + 4*((c + r) % 4))];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      all = a0 ^ a1 ^ a2 ^ a3;
      m[4*c]   = last_i ? a0 : a0 ^ all ^ aes_pkg::gf_double(a0 ^ a1);
      m[4*c+1] = last_i ? a1 : a1 ^ all ^ aes_pkg::gf_double(a1 ^ a2);
      m[4*c+2] = last_i ? a2 : a2 ^ all ^ aes_pkg::gf_double(a2 ^ a3);
      m[4*c+3] = last_i ? a3 : a3 ^ all ^ aes_pkg::gf_double(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) k[i] = aes_pkg::get_byte(key_i, i);
    nk[0] = k[0] ^ aes_pkg::SBOX[k[13]] ^ rcon_i;
    nk[1] = k[1] ^ aes_pkg::SBOX[k[14]];
    nk[2] = k[2] ^ aes_pkg::SBOX[k[15]];
    nk[3] = k[3] ^ aes_pkg::SBOX[k[12]];
    for (int i = 4; i < 16; i++) nk[i] = k[i] ^ nk[i-4];
    for (int i = 0; i < 16; i++) begin
      key_d[127 - 8*i -: 8]   = nk[i];
      state_d[127 - 8*i -: 8] = m[i] ^ nk[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      state_q <= state_d;
      key_q   <= key_d;
    end
  end

  assign state_o = state_q;
  assign key_o   = key_q;

endmodule

/* hw/rtl/aes128_block_encrypt.sv */
// ----------------------------------------------------------------------------
// AES-128 block encryption
// Ten-round pipeline with on-the-fly key expansion.
// ----------------------------------------------------------------------------
// One block and key enter per cycle while the chain advances; each ciphertext
// passes through a chain of ten registered round cells. A stall at the
// output freezes the whole chain, so throughput is one block per cycle while
// the consumer keeps ready high.
module aes128_block_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] plaintext_hi_i,
  input  logic [63:0] plaintext_lo_i,
  input  logic [63:0] key_hi_i,
  input  logic [63:0] key_lo_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] ciphertext_hi_o,
  output logic [63:0] ciphertext_lo_o
);

  localparam int unsigned NR = aes_pkg::NumRounds;

  aes_pkg::block_t st [NR+1];
  aes_pkg::block_t ky [NR+1];
  logic [NR-1:0] vld_q, vld_d;
  logic [7:0] rcon [NR];
  logic adv;

  assign adv = !vld_q[NR-1] || out_ready_i;
  assign in_ready_o = adv;

  assign ky[0] = {key_hi_i, key_lo_i};
  assign st[0] = {plaintext_hi_i, plaintext_lo_i} ^ ky[0];

  always_comb begin
    rcon[0] = 8'h01;
    for (int i = 1; i < NR; i++) rcon[i] = aes_pkg::gf_double(rcon[i-1]);
    vld_d = {vld_q[NR-2:0], in_valid_i};
  end

  for (genvar g = 0; g < NR; g++) begin : g_cell
    aes_round_cell u_cell (
      .clk_i   (clk_i),
      .en_i    (adv),
      .last_i  (g == NR - 1),
      .rcon_i  (rcon[g]),
      .state_i (st[g]),
      .key_i   (ky[g]),
      .state_o (st[g+1]),
      .key_o   (ky[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  assign out_valid_o     = vld_q[NR-1];
  assign ciphertext_hi_o = st[NR][127:64];
  assign ciphertext_lo_o = st[NR][63:0];

endmodule

/* hw/rtl/aes128_block_encrypt_checker.sv */
// ----------------------------------------------------------------------------
// AES-128 port checker
// Handshake and flow checks on the top-level ports.
// ----------------------------------------------------------------------------
`include "aes128_block_encrypt_macros.svh"

module aes128_block_encrypt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] ciphertext_hi_o,
  input logic [63:0] ciphertext_lo_o
);

  `AES_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(ciphertext_hi_o) && $stable(ciphertext_lo_o), "output beat dropped while stalled")
  `AES_ASSERT_IMP(a_ready_free, clk_i, rst_ni, !out_valid_o, in_ready_o, "input stalled with empty output")
  `AES_ASSERT_IMP(a_ready_stall, clk_i, rst_ni, out_valid_o && !out_ready_i, !in_ready_o, "input taken while output stalled")

endmodule

bind aes128_block_encrypt aes128_block_encrypt_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .ciphertext_hi_o (ciphertext_hi_o),
  .ciphertext_lo_o (ciphertext_lo_o)
);

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// AES-128 encryption block testbench
// Drives plaintext/key beats through the valid/ready input channel and
// checks each ciphertext beat in order against a stored known answer or a
// behavioral AES-128 cipher, under phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PipeDepth = 10;
  localparam int unsigned RandBeats = 1600;
  localparam longint unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [63:0] pt_hi;
    logic [63:0] pt_lo;
    logic [63:0] key_hi;
    logic [63:0] key_lo;
  } block_beat_t;

  typedef struct packed {
    logic [63:0] ct_hi;
    logic [63:0] ct_lo;
  } cipher_beat_t;

  typedef struct {
    block_beat_t  beat;
    logic         known;
    cipher_beat_t ct;
  } vector_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [63:0] plaintext_hi_i = '0;
  logic [63:0] plaintext_lo_i = '0;
  logic [63:0] key_hi_i = '0;
  logic [63:0] key_lo_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] ciphertext_hi_o;
  logic [63:0] ciphertext_lo_o;

  cipher_beat_t    ct_pending [$];
  vector_row_t     vectors [$];
  int unsigned     mismatches = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_stall_pct = 0;
  longint unsigned cycles = 0;

  aes128_block_encrypt u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) r ^= a;
      a = xtime(a);
    end
    return r;
  endfunction

  function automatic logic [7:0] sbox_ref(input logic [7:0] x);
    logic [7:0] inv, base, res;
    inv = 8'h01;
    base = x;
    for (int e = 0; e < 8; e++) begin
      if (e != 0) inv = gmul(inv, base);
      base = gmul(base, base);
    end
    res = 8'h63;
    for (int k = 0; k < 5; k++) res ^= (k == 0) ? inv : ((inv << k) | (inv >> (8 - k)));
    return res;
  endfunction

  function automatic cipher_beat_t aes128_encrypt(input block_beat_t b);
    logic [7:0] st [16], rk [16], tmp [16];
    logic [7:0] rcon, a0, a1, a2, a3, all;
    logic [127:0] pt, key, res;
    pt = {b.pt_hi, b.pt_lo};
    key = {b.key_hi, b.key_lo};
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127 - 8*i -: 8];
      st[i] = pt[127 - 8*i -: 8] ^ rk[i];
    end
    rcon = 8'h01;
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) tmp[r + 4*c] = sbox_ref(st[r + 4*((c + r) % 4)]);
      if (rnd != 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          tmp[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
          tmp[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
          tmp[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
          tmp[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
        end
      end
      a0 = sbox_ref(rk[13]); a1 = sbox_ref(rk[14]);
      a2 = sbox_ref(rk[15]); a3 = sbox_ref(rk[12]);
      rk[0] ^= a0 ^ rcon; rk[1] ^= a1; rk[2] ^= a2; rk[3] ^= a3;
      for (int i = 4; i < 16; i++) rk[i] ^= rk[i-4];
      rcon = xtime(rcon);
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[i];
    end
    for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = st[i];
    return '{ct_hi: res[127:64], ct_lo: res[63:0]};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_row(input logic [63:0] ph, input logic [63:0] pl, input logic [63:0] kh,
                         input logic [63:0] kl, input logic known,
                         input logic [63:0] ch, input logic [63:0] cl);
    vector_row_t row;
    row.beat = '{pt_hi: ph, pt_lo: pl, key_hi: kh, key_lo: kl};
    row.known = known;
    row.ct = '{ct_hi: ch, ct_lo: cl};
    vectors.push_back(row);
  endtask

  task automatic send_beat(input block_beat_t b, input cipher_beat_t want);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {plaintext_hi_i, plaintext_lo_i, key_hi_i, key_lo_i} <= b;
    do @(posedge clk_i); while (!in_ready_o);
    ct_pending.push_back(want);
  endtask

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    cipher_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ct_pending.size() == 0) begin
        report_mismatch("unexpected beat", ciphertext_hi_o, '0);
      end else begin
        want = ct_pending.pop_front();
        if (ciphertext_hi_o !== want.ct_hi) report_mismatch("ct_hi", ciphertext_hi_o, want.ct_hi);
        if (ciphertext_lo_o !== want.ct_lo) report_mismatch("ct_lo", ciphertext_lo_o, want.ct_lo);
      end
    end
    out_ready_i <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    block_beat_t  b;
    cipher_beat_t c;
    // FIPS-197 appendix C.1 and appendix B vectors, then extremes and random rows
    add_row(64'h0011223344556677, 64'h8899aabbccddeeff, 64'h0001020304050607,
            64'h08090a0b0c0d0e0f, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    add_row(64'h3243f6a8885a308d, 64'h313198a2e0370734, 64'h2b7e151628aed2a6,
            64'habf7158809cf4f3c, 1'b1, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
    add_row('0, '0, '0, '0, 1'b1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e);
    add_row('1, '1, '0, '0, 1'b0, '0, '0);
    add_row('0, '0, '1, '1, 1'b0, '0, '0);
    add_row('1, '1, '1, '1, 1'b0, '0, '0);
    add_row(64'h8000000000000000, '0, '0, '0, 1'b0, '0, '0);
    add_row('0, 64'h1, '0, 64'h1, 1'b0, '0, '0);
    add_row(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 64'h5555555555555555,
            64'haaaaaaaaaaaaaaaa, 1'b0, '0, '0);
    for (int i = 0; i < 8; i++) add_row(rand64(), rand64(), rand64(), rand64(), 1'b0, '0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (vectors[i]) begin
      c = vectors[i].known ? vectors[i].ct : aes128_encrypt(vectors[i].beat);
      send_beat(vectors[i].beat, c);
    end

    for (int i = 0; i < RandBeats; i++) begin
      case ((i * 5) / RandBeats)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        3: begin send_idle_pct = 17; recv_stall_pct = 17; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      b = {rand64(), rand64(), rand64(), rand64()};
      send_beat(b, aes128_encrypt(b));
    end
    in_valid_i <= 1'b0;

    while (ct_pending.size() != 0) @(posedge clk_i);
    repeat (4 * PipeDepth) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/aes_pkg.sv
hw/rtl/aes_round_cell.sv
hw/rtl/aes128_block_encrypt.sv
hw/rtl/aes128_block_encrypt_checker.sv
bench/tb_top.sv
